FILE: rtl/bmr_pkg.sv
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared types, codes and constants of the bitmap rank code lookup.
// ----------------------------------------------------------------------------
package bmr_pkg;

   localparam int BLOCK_SPAN_DEF = 16;
   localparam int STEP_DEPTH_DEF = 32768;
   localparam int BYTE_DEPTH_DEF = 65536;
   localparam int CATEGORIES_DEF = 100;

   localparam int MID_DEPTH  = 4;
   localparam int OUT_DEPTH  = 16;

   localparam int NUMBER_W   = 14;
   localparam int STEP_SUM_W = 16;
   localparam int BYTE_SUM_W = 30;
   localparam int FIELD_W    = 9;

   typedef enum logic [1:0] {
      OP_MAP_WR  = 2'd0,
      OP_STEP_WR = 2'd1,
      OP_BYTE_WR = 2'd2,
      OP_LOOKUP  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_STEP_WR = 2'd0,
      KIND_BYTE_WR = 2'd1,
      KIND_LOOKUP  = 2'd2,
      KIND_UNSUP   = 2'd3
   } kind_type;

   typedef struct packed {
      op_type                op;
      logic [6:0]            category;
      logic [NUMBER_W-1:0]   number;
      logic [15:0]           addr;
      logic [31:0]           word;
      logic                  map_valid;
      logic [14:0]           step_base;
      logic [15:0]           index_base;
   } req_type;

   typedef struct packed {
      logic [15:0] code;
      logic        unsupported;
   } rsp_type;

   typedef struct packed {
      logic [14:0] step_base;
      logic [15:0] index_base;
   } map_entry_type;

   typedef struct packed {
      kind_type              kind;
      logic [NUMBER_W-1:0]   number;
      logic [15:0]           addr;
      logic [31:0]           word;
      logic [14:0]           step_base;
      logic [15:0]           index_base;
   } cmd_type;

endpackage

FILE: rtl/bmr_ram.sv
// ----------------------------------------------------------------------------
// bmr_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bmr_fifo.sv
// ----------------------------------------------------------------------------
// bmr_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module bmr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty,
   output logic [CW-1:0]    count
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/bmr_divc.sv
// ----------------------------------------------------------------------------
// bmr_divc
// Two-stage division by a constant: reciprocal estimate, then one correction.
// ----------------------------------------------------------------------------
module bmr_divc #(
   parameter int WIDTH   = 16,
   parameter int DIVISOR = 16,
   localparam longint unsigned RECIP = (64'd1 << WIDTH) / DIVISOR,
   localparam int PW = 2 * WIDTH + 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] x,
   output logic [WIDTH-1:0] quot,
   output logic [WIDTH-1:0] rem
);

   logic [PW-1:0]    prod;
   logic [WIDTH-1:0] x_ff, qe_ff, qe_in;
   logic [63:0]      back_prod, diff;
   logic             fix;
   logic [WIDTH-1:0] quot_ff, quot_in, rem_ff, rem_in;

   assign prod  = PW'(x) * PW'(RECIP);
   assign qe_in = prod[2*WIDTH-1:WIDTH];

   assign back_prod = 64'(qe_ff) * 64'(DIVISOR);
   assign diff      = 64'(x_ff) - back_prod;
   assign fix       = (diff >= 64'(DIVISOR));
   assign rem_in    = fix ? WIDTH'(diff - 64'(DIVISOR)) : WIDTH'(diff);
   assign quot_in   = qe_ff + WIDTH'(fix);

   always_ff @(posedge clock) begin
      x_ff    <= x;
      qe_ff   <= qe_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

FILE: rtl/bmr_front.sv
// ----------------------------------------------------------------------------
// bmr_front
// Request side: accept transactions, keep the category map, classify items.
// ----------------------------------------------------------------------------
module bmr_front
   import bmr_pkg::*;
#(
   parameter int CATEGORIES  = CATEGORIES_DEF,
   parameter int QUEUE_DEPTH = MID_DEPTH,
   localparam int CA = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  req_type       req_data,
   input  logic [CW-1:0] q_count,
   output logic          q_push,
   output cmd_type       q_data
);

   logic          accept, cat_ok, map_wr;
   logic [CA-1:0] cat_idx;
   logic          map_valid_ff [CATEGORIES];
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_hit_ff, s1_hit_in;
   req_type       s1_req_ff;
   logic [$bits(map_entry_type)-1:0] map_rd;
   map_entry_type map_entry;

   assign req_full = (32'(q_count) + 32'(s1_valid_ff)) >= 32'(QUEUE_DEPTH);
   assign accept   = req_push && !req_full;
   assign cat_ok   = 32'(req_data.category) < 32'(CATEGORIES);
   assign cat_idx  = CA'(req_data.category);
   assign map_wr   = accept && (req_data.op == OP_MAP_WR) && cat_ok;
   assign s1_valid_in = accept && (req_data.op != OP_MAP_WR);
   assign s1_hit_in   = cat_ok && map_valid_ff[cat_idx];

   bmr_ram #(
      .WIDTH ($bits(map_entry_type)),
      .DEPTH (CATEGORIES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr),
      .wr_addr (cat_idx),
      .wr_data ({req_data.step_base, req_data.index_base}),
      .rd_addr (cat_idx),
      .rd_data (map_rd)
   );

   assign map_entry = map_entry_type'(map_rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < CATEGORIES; i++) begin
            map_valid_ff[i] <= 1'b0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (map_wr) begin
            map_valid_ff[cat_idx] <= req_data.map_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
         s1_hit_ff <= s1_hit_in;
      end
   end

   always_comb begin
      q_data            = '0;
      q_data.number     = s1_req_ff.number;
      q_data.addr       = s1_req_ff.addr;
      q_data.word       = s1_req_ff.word;
      q_data.step_base  = map_entry.step_base;
      q_data.index_base = map_entry.index_base;
      unique case (s1_req_ff.op)
         OP_STEP_WR: q_data.kind = KIND_STEP_WR;
         OP_BYTE_WR: q_data.kind = KIND_BYTE_WR;
         OP_LOOKUP:  q_data.kind = s1_hit_ff ? KIND_LOOKUP : KIND_UNSUP;
         default:    q_data.kind = KIND_UNSUP;
      endcase
   end

   assign q_push = s1_valid_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> 32'(q_count) < 32'(QUEUE_DEPTH))
      else $error("command queue pushed while full");

endmodule

FILE: rtl/bmr_back.sv
// ----------------------------------------------------------------------------
// bmr_back
// Execution pipeline: store writes, step word read, rank, packed field read.
// ----------------------------------------------------------------------------
module bmr_back
   import bmr_pkg::*;
#(
   parameter int BLOCK_SPAN   = BLOCK_SPAN_DEF,
   parameter int STEP_DEPTH   = STEP_DEPTH_DEF,
   parameter int BYTE_DEPTH   = BYTE_DEPTH_DEF,
   parameter int RESULT_DEPTH = OUT_DEPTH,
   localparam int LAT = 11,
   localparam int SA  = $clog2(STEP_DEPTH),
   localparam int BA  = $clog2(BYTE_DEPTH),
   localparam int RW  = $clog2(BLOCK_SPAN),
   localparam int PW  = $clog2(RESULT_DEPTH + 1)
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   input  logic    res_taken,
   output logic    res_valid,
   output rsp_type res_data
);

   typedef struct packed {
      logic        direct;
      logic [15:0] dcode;
      logic [2:0]  pos;
   } late_type;

   cmd_type       line_ff [LAT];
   logic          vld_ff  [LAT];
   logic [PW-1:0] pending_ff, pending_in;
   logic          head_res;

   logic [NUMBER_W-1:0]   nq, nr;
   logic [RW-1:0]         nrem_ff [3];
   logic [STEP_SUM_W-1:0] ssum, saddr;
   logic [31:0]           sw;
   logic                  step_we;

   logic [15:0] weight, mask;
   logic [4:0]  cnt;
   logic [31:0] rank_in, rank_ff, r9_ff;
   late_type    late_in;
   late_type    late_ff [5];

   logic [BYTE_SUM_W-1:0] bsum, bres;
   logic [BA-1:0]         a0, a1;
   logic [BA:0]           a0p;
   logic                  byte_we;
   logic [7:0]            b0, b1;
   logic [15:0]           pair, shifted;

   // issue: lookups need a free result slot
   assign head_res = (cmd_data.kind == KIND_LOOKUP) || (cmd_data.kind == KIND_UNSUP);
   assign cmd_pop  = !cmd_empty && (!head_res || (pending_ff < PW'(RESULT_DEPTH)));

   always_comb begin
      pending_in = pending_ff;
      if ((cmd_pop && head_res) && !res_taken) begin
         pending_in = pending_ff + PW'(1);
      end else if (!(cmd_pop && head_res) && res_taken) begin
         pending_in = pending_ff - PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         pending_ff <= pending_in;
         vld_ff[0]  <= cmd_pop;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      line_ff[0] <= cmd_data;
      for (int i = 1; i < LAT; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   // number split into step index and bit position
   bmr_divc #(
      .WIDTH   (NUMBER_W),
      .DIVISOR (BLOCK_SPAN)
   ) u_num_div (
      .clock (clock),
      .x     (line_ff[0].number),
      .quot  (nq),
      .rem   (nr)
   );

   assign ssum = STEP_SUM_W'(line_ff[2].step_base) + STEP_SUM_W'(nq);

   bmr_divc #(
      .WIDTH   (STEP_SUM_W),
      .DIVISOR (STEP_DEPTH)
   ) u_step_div (
      .clock (clock),
      .x     (ssum),
      .quot  (),
      .rem   (saddr)
   );

   always_ff @(posedge clock) begin
      nrem_ff[0] <= RW'(nr);
      nrem_ff[1] <= nrem_ff[0];
      nrem_ff[2] <= nrem_ff[1];
   end

   assign step_we = vld_ff[4] && (line_ff[4].kind == KIND_STEP_WR)
                    && (32'(line_ff[4].addr) < 32'(STEP_DEPTH));

   bmr_ram #(
      .WIDTH (32),
      .DEPTH (STEP_DEPTH)
   ) u_step_ram (
      .clock   (clock),
      .wr_en   (step_we),
      .wr_addr (SA'(line_ff[4].addr)),
      .wr_data (line_ff[4].word),
      .rd_addr (SA'(saddr)),
      .rd_data (sw)
   );

   // rank = signed pivot + weight bits below the position
   assign weight  = sw[31:16];
   assign mask    = (16'd1 << nrem_ff[2]) - 16'd1;
   assign cnt     = 5'($countones(weight & mask));
   assign rank_in = {{16{sw[15]}}, sw[15:0]} + 32'(cnt);

   always_comb begin
      late_in.direct = (weight == 16'd0);
      late_in.dcode  = sw[15:0];
      late_in.pos    = rank_in[2:0];
   end

   always_ff @(posedge clock) begin
      rank_ff    <= rank_in;
      r9_ff      <= rank_ff + (rank_ff << 3);
      late_ff[0] <= late_in;
      for (int i = 1; i < 5; i++) begin
         late_ff[i] <= late_ff[i-1];
      end
   end

   assign bsum = BYTE_SUM_W'(line_ff[7].index_base) + BYTE_SUM_W'(r9_ff[31:3]);

   bmr_divc #(
      .WIDTH   (BYTE_SUM_W),
      .DIVISOR (BYTE_DEPTH)
   ) u_byte_div (
      .clock (clock),
      .x     (bsum),
      .quot  (),
      .rem   (bres)
   );

   assign a0  = BA'(bres);
   assign a0p = (BA+1)'(a0) + (BA+1)'(1);
   assign a1  = (a0p == (BA+1)'(BYTE_DEPTH)) ? '0 : BA'(a0p);

   assign byte_we = vld_ff[9] && (line_ff[9].kind == KIND_BYTE_WR)
                    && (32'(line_ff[9].addr) < 32'(BYTE_DEPTH));

   bmr_ram #(
      .WIDTH (8),
      .DEPTH (BYTE_DEPTH)
   ) u_byte_ram_hi (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (BA'(line_ff[9].addr)),
      .wr_data (line_ff[9].word[7:0]),
      .rd_addr (a0),
      .rd_data (b0)
   );

   bmr_ram #(
      .WIDTH (8),
      .DEPTH (BYTE_DEPTH)
   ) u_byte_ram_lo (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (BA'(line_ff[9].addr)),
      .wr_data (line_ff[9].word[7:0]),
      .rd_addr (a1),
      .rd_data (b1)
   );

   assign pair    = {b0, b1};
   assign shifted = pair >> (3'd7 - late_ff[4].pos);

   always_comb begin
      res_data.unsupported = (line_ff[10].kind == KIND_UNSUP);
      if (line_ff[10].kind == KIND_UNSUP) begin
         res_data.code = 16'd0;
      end else if (late_ff[4].direct) begin
         res_data.code = late_ff[4].dcode;
      end else begin
         res_data.code = 16'(shifted[FIELD_W-1:0]);
      end
   end

   assign res_valid = vld_ff[10]
                      && ((line_ff[10].kind == KIND_LOOKUP) || (line_ff[10].kind == KIND_UNSUP));

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PW'(RESULT_DEPTH))
      else $error("result credit count above queue depth");

   a_result_owned: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> pending_ff != '0)
      else $error("result produced without an issued lookup");

endmodule

FILE: rtl/bitmap_rank_packed_code_lookup.sv
// ----------------------------------------------------------------------------
// bitmap_rank_packed_code_lookup
// Compressed code lookup by bitmap rank over step words and packed 9-bit fields.
// ----------------------------------------------------------------------------
// Every cycle one transaction can be pushed: a map entry write, a step word
// write, a packed byte write or a lookup. Only lookups return a result, in
// request order, through the rsp_ queue. One transaction per cycle flows
// while req_full is low and lookups find a free result slot, as the back
// pipeline's step store and packed byte store each serve one access per
// cycle. The category map is cleared by reset at once; the step and byte
// stores have no clearing pass and must be written before use.
module bitmap_rank_packed_code_lookup
   import bmr_pkg::*;
#(
   parameter int BLOCK_SPAN = BLOCK_SPAN_DEF,
   parameter int STEP_DEPTH = STEP_DEPTH_DEF,
   parameter int BYTE_DEPTH = BYTE_DEPTH_DEF,
   parameter int CATEGORIES = CATEGORIES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int QCW = $clog2(MID_DEPTH + 1);

   logic                          q_push, q_empty, q_pop;
   cmd_type                       q_in_data, q_head;
   logic [$bits(cmd_type)-1:0]    q_out_data;
   logic [QCW-1:0]                q_count;
   logic                          res_valid, res_taken, out_full;
   rsp_type                       res_data;
   logic [$bits(rsp_type)-1:0]    out_data;

   bmr_front #(
      .CATEGORIES  (CATEGORIES),
      .QUEUE_DEPTH (MID_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   bmr_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (MID_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .full      (),
      .empty     (q_empty),
      .count     (q_count)
   );

   assign q_head = cmd_type'(q_out_data);

   bmr_back #(
      .BLOCK_SPAN   (BLOCK_SPAN),
      .STEP_DEPTH   (STEP_DEPTH),
      .BYTE_DEPTH   (BYTE_DEPTH),
      .RESULT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (q_empty),
      .cmd_data  (q_head),
      .cmd_pop   (q_pop),
      .res_taken (res_taken),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   bmr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop       (rsp_pop),
      .pop_data  (out_data),
      .full      (out_full),
      .empty     (rsp_empty),
      .count     ()
   );

   assign rsp_data  = rsp_type'(out_data);
   assign res_taken = rsp_pop && !rsp_empty;

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !out_full)
      else $error("result dropped on a full response queue");

endmodule
